// ----- sv/fsq_pkg.sv -----
package fsq_pkg;

  // Widths fixed by the item format.
  localparam int unsigned ChannelW   = 2;
  localparam int unsigned VoltageW   = 17;
  localparam int unsigned FrameW     = 24;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned SpanCodeW  = 3;
  localparam int unsigned MaxChannels = 8;

  // Command queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Q4.12 limits: clamp at 10.799 V, span thresholds at 5 V and 10 V.
  localparam logic signed [VoltageW-1:0] VClampPos = 17'sd44232;
  localparam logic signed [VoltageW-1:0] VClampNeg = -17'sd44232;
  localparam logic [15:0] LimFive = 16'd20480;
  localparam logic [15:0] LimTen  = 16'd40960;

  // Span selectors and the range code that never matches a real span.
  localparam logic [1:0] Span5V   = 2'd0;
  localparam logic [1:0] Span10V  = 2'd1;
  localparam logic [1:0] Span10V8 = 2'd2;
  localparam logic [SpanCodeW-1:0] BipolarOffset = 3'd3;
  localparam logic [SpanCodeW-1:0] SpanInvalid   = 3'd7;

  // Reciprocals for exact division of a numerator below 2**21.
  localparam logic [21:0] Recip5  = 22'd3355444;  // ceil(2**24 / 5)
  localparam logic [21:0] Recip27 = 22'd2485514;  // ceil(2**26 / 27)
  localparam int unsigned Shift5  = 24;
  localparam int unsigned Shift27 = 26;

  // DAC register select codes and the load address.
  localparam logic [2:0] RegData     = 3'd0;
  localparam logic [2:0] RegRange    = 3'd1;
  localparam logic [2:0] RegPower    = 3'd2;
  localparam logic [2:0] RegCtrl     = 3'd3;
  localparam logic [2:0] CtrlLoadAdr = 3'd5;

  // One classified request, as handed from the front to the back.
  typedef struct packed {
    logic                   need_power;
    logic [MaxChannels-1:0] power_data;
    logic                   need_range;
    logic [SpanCodeW-1:0]   span_code;
    logic [ChannelW-1:0]    channel;
    logic [CodeW-1:0]       code;
  } cmd_t;

  typedef enum logic [3:0] {
    STEP_POWER = 4'b0001,
    STEP_RANGE = 4'b0010,
    STEP_DATA  = 4'b0100,
    STEP_LOAD  = 4'b1000
  } step_e;

  function automatic logic [FrameW-1:0] make_frame(logic [2:0] reg_sel, logic [2:0] addr,
                                                   logic [CodeW-1:0] data);
    return {2'b00, reg_sel, addr, data};
  endfunction

endpackage

// ----- sv/dac_voltage_frame_sequencer_top.sv -----
// Command sequencer for a quad bipolar DAC. Each input word carries a channel
// number and a signed Q4.12 target voltage; the block clamps the voltage to
// +/-10.799 V, picks the smallest span that holds it (5 V, 10 V or 10.8 V),
// converts it to a 16-bit code (straight binary for zero and positive values,
// two's complement for negative ones) and emits the 24-bit serial command
// words for it: a power-on word if the channel is still off, a range word if
// the channel's span or polarity changes, the data word and finally the load
// word, which is flagged with tlast. A request for a channel at or beyond
// CHANNEL_COUNT is accepted and dropped without output. The front end
// classifies a word and updates the channel state in the cycle it is taken,
// computes the code in the next cycle and places the finished command in a
// two-entry queue; the back end turns one command into two to four output
// words, one per cycle while the output is not stalled, through an output
// register, so the sustained request rate is set by the number of words each
// request produces. The input keeps taking words while the queue has room,
// also while earlier requests are still being sent. The first word of a
// request passes through the stage register, the queue and the output
// register before it is presented on the output.
module dac_voltage_frame_sequencer_top #(
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [1:0] channel, [18:2] target_voltage, [23:19] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [23:0] serial_frame
  output logic        m_axis_tlast_o    // last_frame
);
  import fsq_pkg::*;

  logic                        push_valid;
  logic                        push_ready;
  cmd_t                        push_cmd;
  logic                        cmd_valid;
  logic                        cmd_pop;
  cmd_t                        cmd;
  logic [ChannelW-1:0]         in_channel;
  logic signed [VoltageW-1:0]  in_voltage;

  assign in_channel = s_axis_tdata_i[ChannelW-1:0];
  assign in_voltage = s_axis_tdata_i[ChannelW+VoltageW-1:ChannelW];

  fsq_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_channel_i(in_channel),
    .in_voltage_i(in_voltage),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  fsq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (cmd_valid),
    .pop_ready_i (cmd_pop),
    .pop_cmd_o   (cmd)
  );

  fsq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_frame_o(m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule

// ----- sv/fsq_front.sv -----
module fsq_front #(
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [fsq_pkg::ChannelW-1:0]           in_channel_i,
  input  logic signed [fsq_pkg::VoltageW-1:0]    in_voltage_i,
  output logic                                   push_valid_o,
  input  logic                                   push_ready_i,
  output fsq_pkg::cmd_t                          push_cmd_o
);
  import fsq_pkg::*;

  localparam int unsigned ChIdxW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  // Classification of the incoming word.
  logic                        in_accept;
  logic                        ch_ok;
  logic [ChIdxW+1:0]           ch_ext;
  logic [ChIdxW-1:0]           ch_idx;
  logic [CHANNEL_COUNT-1:0]    ch_bit;
  logic signed [VoltageW-1:0]  x_clamp;
  logic                        neg;
  logic [15:0]                 mag;
  logic [1:0]                  span;
  logic [SpanCodeW-1:0]        span_code;

  // Channel state.
  logic [CHANNEL_COUNT-1:0]    powered_q, powered_d;
  logic [SpanCodeW-1:0]        span_q [CHANNEL_COUNT];

  // Stage register between classification and code arithmetic.
  logic                        s1_valid_q, s1_valid_d;
  logic [ChannelW-1:0]         s1_ch_q;
  logic [15:0]                 s1_mag_q;
  logic                        s1_neg_q;
  logic [1:0]                  s1_span_q;
  logic                        s1_need_power_q;
  logic [MaxChannels-1:0]      s1_power_data_q;
  logic                        s1_need_range_q;
  logic [SpanCodeW-1:0]        s1_span_code_q;

  // Code arithmetic.
  logic [20:0]                 num_u;
  logic [20:0]                 num;
  logic [21:0]                 recip;
  logic [42:0]                 prod;
  logic [42:0]                 q_full;
  logic [16:0]                 q;
  logic [16:0]                 q_neg;
  logic [CodeW-1:0]            code;

  assign in_ready_o = !s1_valid_q || push_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    ch_ok  = (32'(in_channel_i) < CHANNEL_COUNT);
    ch_ext = (ChIdxW + 2)'(in_channel_i);
    ch_idx = ch_ext[ChIdxW-1:0];
    ch_bit = '0;
    ch_bit[ch_idx] = 1'b1;

    if (in_voltage_i > VClampPos) begin
      x_clamp = VClampPos;
    end else if (in_voltage_i < VClampNeg) begin
      x_clamp = VClampNeg;
    end else begin
      x_clamp = in_voltage_i;
    end
    neg = x_clamp[VoltageW-1];
    mag = neg ? 16'(-x_clamp) : 16'(x_clamp);

    if (mag > LimTen) begin
      span = Span10V8;
    end else if (mag > LimFive) begin
      span = Span10V;
    end else begin
      span = Span5V;
    end
    span_code = {1'b0, span} + (neg ? BipolarOffset : 3'd0);
    powered_d = powered_q | ch_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        span_q[i] <= SpanInvalid;
      end
    end else if (in_accept && ch_ok) begin
      powered_q      <= powered_d;
      span_q[ch_idx] <= span_code;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i && ch_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && ch_ok) begin
      s1_ch_q         <= in_channel_i;
      s1_mag_q        <= mag;
      s1_neg_q        <= neg;
      s1_span_q       <= span;
      s1_need_power_q <= !powered_q[ch_idx];
      s1_power_data_q <= MaxChannels'(powered_d);
      s1_need_range_q <= (span_q[ch_idx] != span_code);
      s1_span_code_q  <= span_code;
    end
  end

  // Unipolar numerator is 16, 8 or 40 times the magnitude; bipolar is half.
  always_comb begin
    unique case (s1_span_q)
      Span5V:   num_u = {s1_mag_q, 5'b0} >> 1;
      Span10V:  num_u = {2'b0, s1_mag_q, 3'b0};
      Span10V8: num_u = {s1_mag_q, 5'b0} + {2'b0, s1_mag_q, 3'b0};
      default:  num_u = '0;
    endcase
    num   = s1_neg_q ? (num_u >> 1) : num_u;
    recip = (s1_span_q == Span10V8) ? Recip27 : Recip5;
    prod  = 43'(num) * 43'(recip);
    q_full = (s1_span_q == Span10V8) ? (prod >> Shift27) : (prod >> Shift5);
    q      = q_full[16:0];
    q_neg  = 17'd0 - q;
    if (s1_neg_q) begin
      code = q_neg[CodeW-1:0];
    end else if (q[16]) begin
      code = '1;
    end else begin
      code = q[CodeW-1:0];
    end
  end

  assign push_valid_o          = s1_valid_q;
  assign push_cmd_o.need_power = s1_need_power_q;
  assign push_cmd_o.power_data = s1_power_data_q;
  assign push_cmd_o.need_range = s1_need_range_q;
  assign push_cmd_o.span_code  = s1_span_code_q;
  assign push_cmd_o.channel    = s1_ch_q;
  assign push_cmd_o.code       = code;

endmodule

// ----- sv/fsq_queue.sv -----
module fsq_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fsq_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fsq_pkg::cmd_t pop_cmd_o
);
  import fsq_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (32'(count_q) < QueueDepth);
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- sv/fsq_back.sv -----
module fsq_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  fsq_pkg::cmd_t                 cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fsq_pkg::FrameW-1:0]    out_frame_o,
  output logic                          out_last_o
);
  import fsq_pkg::*;

  step_e              step_q, step_d;
  step_e              kind;
  logic               emit;
  logic [FrameW-1:0]  frame;
  logic [2:0]         addr;
  logic               out_valid_q, out_valid_d;
  logic [FrameW-1:0]  out_frame_q;
  logic               out_last_q;

  assign addr = 3'(cmd_i.channel);
  assign emit = cmd_valid_i && (!out_valid_q || out_ready_i);

  // Skip the power and range frames when the command does not need them.
  always_comb begin
    kind = step_q;
    if (kind == STEP_POWER && !cmd_i.need_power) begin
      kind = STEP_RANGE;
    end
    if (kind == STEP_RANGE && !cmd_i.need_range) begin
      kind = STEP_DATA;
    end

    frame  = make_frame(RegCtrl, CtrlLoadAdr, '0);
    step_d = step_q;
    unique case (kind)
      STEP_POWER: begin
        frame = make_frame(RegPower, 3'd0, CodeW'(cmd_i.power_data));
        if (emit) step_d = STEP_RANGE;
      end
      STEP_RANGE: begin
        frame = make_frame(RegRange, addr, CodeW'(cmd_i.span_code));
        if (emit) step_d = STEP_DATA;
      end
      STEP_DATA: begin
        frame = make_frame(RegData, addr, cmd_i.code);
        if (emit) step_d = STEP_LOAD;
      end
      STEP_LOAD: begin
        frame = make_frame(RegCtrl, CtrlLoadAdr, '0);
        if (emit) step_d = STEP_POWER;
      end
      default: begin
        step_d = STEP_POWER;
      end
    endcase
  end

  assign cmd_pop_o = emit && (kind == STEP_LOAD);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_POWER;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_frame_q <= frame;
      out_last_q  <= (kind == STEP_LOAD);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_frame_o = out_frame_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- tb/dac_voltage_frame_sequencer_top_tb.sv -----
`timescale 1ns / 1ps

module dac_voltage_frame_sequencer_top_tb;
  import fsq_pkg::*;

  localparam int unsigned ChannelCount = 4;
  localparam int unsigned RandomRequests = 320;
  localparam int unsigned StallLimit = 200;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxPrinted = 30;

  // One request word as it enters the block.
  typedef struct packed {
    logic signed [VoltageW-1:0] volt;
    logic [ChannelW-1:0]        channel;
  } dac_request_t;

  // One command word as it leaves the block.
  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic              last;
  } dac_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  dac_voltage_frame_sequencer_top #(
    .CHANNEL_COUNT(ChannelCount)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Shadow copy of the channel state kept by the block.
  logic [ChannelCount-1:0] powered_mask;
  logic [SpanCodeW-1:0]    sent_span [ChannelCount];

  dac_request_t request_q[$];
  dac_word_t    expected_words[$];

  dac_request_t cur_req = '0;
  logic         send_busy = 1'b0;
  logic         send_burst = 1'b0;
  int unsigned  send_gap = 0;
  logic         recv_burst = 1'b0;
  int unsigned  recv_stall = 0;

  int unsigned total_requests = 0;
  int unsigned requests_taken = 0;
  int unsigned words_checked = 0;
  int unsigned range_words = 0;
  int unsigned power_words = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int          prev_volt [ChannelCount];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrinted) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic queue_request(input int ch, input int volt);
    dac_request_t req;
    req.channel = ch[ChannelW-1:0];
    req.volt    = volt[VoltageW-1:0];
    request_q.push_back(req);
  endtask

  function automatic void push_word(input logic [FrameW-1:0] frame, input logic last);
    dac_word_t w;
    w.frame = frame;
    w.last  = last;
    expected_words.push_back(w);
  endfunction

  // Works out the command words one request produces and updates the shadow
  // channel state the way the block does.
  function automatic void sequence_request(input dac_request_t req);
    int          v;
    int unsigned mag;
    int unsigned scale;
    int unsigned divisor;
    logic [31:0] quot;
    logic [31:0] neg_quot;
    logic [1:0]  span;
    logic [SpanCodeW-1:0] span_code;
    logic [CodeW-1:0]     code;
    logic        neg;

    if (int'(req.channel) >= int'(ChannelCount)) return;

    v = $signed(req.volt);
    if (v > int'(VClampPos)) v = int'(VClampPos);
    if (v < int'(VClampNeg)) v = int'(VClampNeg);
    neg = (v < 0);
    mag = neg ? -v : v;

    span = Span5V;
    if (mag > LimFive) span = Span10V;
    if (mag > LimTen) span = Span10V8;

    // Codes per volt: 65536/5, 65536/10 and 65536/10.8 for unipolar; the
    // bipolar scale is half of that since the code covers both polarities.
    case (span)
      Span5V: begin
        scale = 16;
        divisor = 5;
      end
      Span10V: begin
        scale = 8;
        divisor = 5;
      end
      default: begin
        scale = 40;
        divisor = 27;
      end
    endcase
    if (neg) scale = scale / 2;
    quot = (scale * mag) / divisor;

    if (!neg) begin
      code = (quot > 32'd65535) ? 16'hFFFF : quot[CodeW-1:0];
    end else begin
      neg_quot = 32'd0 - quot;
      code = neg_quot[CodeW-1:0];
    end
    span_code = {1'b0, span} + (neg ? BipolarOffset : 3'd0);

    if (!powered_mask[req.channel]) begin
      powered_mask[req.channel] = 1'b1;
      push_word({2'b00, RegPower, 3'd0, 12'd0, powered_mask}, 1'b0);
      power_words++;
    end
    if (sent_span[req.channel] != span_code) begin
      sent_span[req.channel] = span_code;
      push_word({2'b00, RegRange, 1'b0, req.channel, 13'd0, span_code}, 1'b0);
      range_words++;
    end
    push_word({2'b00, RegData, 1'b0, req.channel, code}, 1'b0);
    push_word({2'b00, RegCtrl, CtrlLoadAdr, 16'd0}, 1'b1);
  endfunction

  // Request driver. A random gap is drawn after each accepted word; now and
  // then the driver switches into a burst mode with no gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_o) begin
        sequence_request(cur_req);
        requests_taken++;
        if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 9);
        send_busy = 1'b0;
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          send_busy = 1'b1;
        end
      end
      s_axis_tvalid <= send_busy;
      s_axis_tdata  <= {5'd0, cur_req.volt, cur_req.channel};
    end
  end

  // Output monitor. Each accepted word is checked against the oldest
  // expectation, then tready is held low for a drawn number of cycles.
  always @(posedge clk_i) begin
    dac_word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %06h last=%0b",
                                    m_axis_tdata_o, m_axis_tlast_o));
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata_o !== want.frame)
            report_mismatch($sformatf("frame %06h, expected %06h",
                                      m_axis_tdata_o, want.frame));
          if (m_axis_tlast_o !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b on frame %06h",
                                      m_axis_tlast_o, want.last, want.frame));
        end
        words_checked++;
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 9);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_axis_tready <= (recv_stall == 0);
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: %0d of %0d requests taken, %0d words still expected",
                   requests_taken, total_requests, expected_words.size());
          $display("[dac_voltage_frame_sequencer_top] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int ch;
    int volt;
    int base;

    powered_mask = '0;
    foreach (sent_span[i]) sent_span[i] = SpanInvalid;
    foreach (prev_volt[i]) prev_volt[i] = 0;

    // Directed part: zero on a fresh channel, a repeat that needs neither a
    // power nor a range word, both span thresholds on either side, positive
    // full scale saturation, the clamp and the extremes of the field.
    queue_request(0, 0);
    queue_request(0, 0);
    queue_request(0, 1);
    queue_request(1, -1);
    queue_request(2, 20480);
    queue_request(3, 20481);
    queue_request(0, 40960);
    queue_request(1, 40961);
    queue_request(2, 44232);
    queue_request(3, 44233);
    queue_request(0, 65535);
    queue_request(1, -20480);
    queue_request(2, -20481);
    queue_request(3, -40960);
    queue_request(0, -40961);
    queue_request(1, -44232);
    queue_request(2, -44233);
    queue_request(3, -65536);
    queue_request(0, -65536);
    queue_request(1, 0);

    // Random part: full-range values, values inside the clamp, values near
    // the thresholds, tiny values and repeats of the channel's last random value.
    for (int i = 0; i < RandomRequests; i++) begin
      ch = $urandom_range(0, ChannelCount - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: volt = $signed($urandom() & 32'h1FFFF) - (($urandom() & 1) ? 65536 : 0);
        4, 5: volt = int'($urandom_range(0, 88464)) - 44232;
        6, 7: begin
          case ($urandom_range(0, 2))
            0: base = int'(LimFive);
            1: base = int'(LimTen);
            default: base = int'(VClampPos);
          endcase
          volt = base + int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 1)) volt = -volt;
        end
        8: volt = int'($urandom_range(0, 2)) - 1;
        default: volt = prev_volt[ch];
      endcase
      // Keep the value inside the 17-bit field.
      volt = $signed(volt[VoltageW-1:0]);
      prev_volt[ch] = volt;
      queue_request(ch, volt);
    end
    total_requests = request_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_taken < total_requests || expected_words.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));

    $display("Sent %0d requests over four channels; checked %0d command words,",
             requests_taken, words_checked);
    $display("including %0d power-on and %0d range words.", power_words, range_words);
    if (error_count == 0) begin
      $display("[dac_voltage_frame_sequencer_top] OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[dac_voltage_frame_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/fsq_pkg.sv
sv/fsq_front.sv
sv/fsq_queue.sv
sv/fsq_back.sv
sv/dac_voltage_frame_sequencer_top.sv
tb/dac_voltage_frame_sequencer_top_tb.sv
